/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: transaction payloads,
// command and status codes, controller states and datapath operations.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int unsigned DATA_W = 32;

   typedef struct packed {
      logic [1:0]               cmd;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic                     is_empty;
      logic [1:0]               status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_PUSH_RD,
      S_PUSH_CMP,
      S_PUSH_PLACE,
      S_POP_RD,
      S_POP_TOP,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ERR_EMPTY,
      OP_ERR_FULL,
      OP_PUSH_FIRST,
      OP_PUSH_RD,
      OP_PUSH_SHIFT,
      OP_PUSH_PLACE,
      OP_POP_LAST,
      OP_POP_RD,
      OP_POP_TOP,
      OP_RESP
   } op_type;

   // datapath flags seen by the controller
   typedef struct packed {
      logic is_push;
      logic is_pop;
      logic full;
      logic empty;
      logic one;
      logic shift;    // stored entry >= new value, move it up
      logic idx_one;
      logic rsp_free;
   } dp_status_type;

endpackage

/* sv/spq_ram.sv */
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller for the sorted priority queue: sequences one transaction at a
// time through dispatch, insertion or removal, and result hand-off.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spq_pkg::dp_status_type dp_status,
   output spq_pkg::op_type       dp_op
);

   spq_pkg::state_type state_ff;
   spq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = spq_pkg::S_DISPATCH;
            end
         end
         spq_pkg::S_DISPATCH: begin
            if (dp_status.is_push && !dp_status.full && !dp_status.empty) begin
               state_in = spq_pkg::S_PUSH_RD;
            end else if (dp_status.is_pop && !dp_status.empty && !dp_status.one) begin
               state_in = spq_pkg::S_POP_RD;
            end else begin
               state_in = spq_pkg::S_DONE;
            end
         end
         spq_pkg::S_PUSH_RD: begin
            state_in = spq_pkg::S_PUSH_CMP;
         end
         spq_pkg::S_PUSH_CMP: begin
            if (!dp_status.shift) begin
               state_in = spq_pkg::S_DONE;
            end else if (dp_status.idx_one) begin
               state_in = spq_pkg::S_PUSH_PLACE;
            end else begin
               state_in = spq_pkg::S_PUSH_RD;
            end
         end
         spq_pkg::S_PUSH_PLACE: begin
            state_in = spq_pkg::S_DONE;
         end
         spq_pkg::S_POP_RD: begin
            state_in = spq_pkg::S_POP_TOP;
         end
         spq_pkg::S_POP_TOP: begin
            state_in = spq_pkg::S_DONE;
         end
         spq_pkg::S_DONE: begin
            if (dp_status.rsp_free) begin
               state_in = spq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      dp_op     = spq_pkg::OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            // nothing is taken while reset is held
            req_stall = reset;
            if (req_valid) begin
               dp_op = spq_pkg::OP_LOAD;
            end
         end
         spq_pkg::S_DISPATCH: begin
            if (dp_status.is_push) begin
               if (dp_status.full) begin
                  dp_op = spq_pkg::OP_ERR_FULL;
               end else if (dp_status.empty) begin
                  dp_op = spq_pkg::OP_PUSH_FIRST;
               end
            end else if (dp_status.empty) begin
               dp_op = spq_pkg::OP_ERR_EMPTY;
            end else if (dp_status.is_pop && dp_status.one) begin
               dp_op = spq_pkg::OP_POP_LAST;
            end
         end
         spq_pkg::S_PUSH_RD: begin
            dp_op = spq_pkg::OP_PUSH_RD;
         end
         spq_pkg::S_PUSH_CMP: begin
            dp_op = dp_status.shift ? spq_pkg::OP_PUSH_SHIFT : spq_pkg::OP_PUSH_PLACE;
         end
         spq_pkg::S_PUSH_PLACE: begin
            dp_op = spq_pkg::OP_PUSH_PLACE;
         end
         spq_pkg::S_POP_RD: begin
            dp_op = spq_pkg::OP_POP_RD;
         end
         spq_pkg::S_POP_TOP: begin
            dp_op = spq_pkg::OP_POP_TOP;
         end
         spq_pkg::S_DONE: begin
            if (dp_status.rsp_free) begin
               dp_op = spq_pkg::OP_RESP;
            end
         end
         default: begin
            dp_op = spq_pkg::OP_NONE;
         end
      endcase
   end

endmodule

/* sv/spq_datapath.sv */
// ----------------------------------------------------------------------------
// spq_datapath
// Datapath for the sorted priority queue: entry RAM in ascending order
// (largest at fill_count-1), fill count, cached top value, insertion index
// and the result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::req_type       req_data,
   input  spq_pkg::op_type        dp_op,
   output spq_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output spq_pkg::rsp_type       rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = spq_pkg::DATA_W;

   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic signed [DW-1:0]   val_ff, val_in;
   logic signed [DW-1:0]   top_ff, top_in;
   logic [1:0]             status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [DW-1:0]          ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [DW-1:0]          ram_rd_data;

   spq_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      ram_wr_en   = (dp_op == spq_pkg::OP_PUSH_FIRST) || (dp_op == spq_pkg::OP_PUSH_SHIFT)
                    || (dp_op == spq_pkg::OP_PUSH_PLACE);
      ram_wr_addr = (dp_op == spq_pkg::OP_PUSH_FIRST) ? '0 : idx_ff;
      ram_wr_data = (dp_op == spq_pkg::OP_PUSH_SHIFT) ? ram_rd_data : val_ff;
      ram_rd_en   = (dp_op == spq_pkg::OP_PUSH_RD) || (dp_op == spq_pkg::OP_POP_RD);
      // pop reads the entry just below the current top
      ram_rd_addr = (dp_op == spq_pkg::OP_POP_RD) ? AW'(count_ff - CW'(2))
                                                  : AW'(idx_ff - AW'(1));
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      top_in       = top_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (dp_op)
         spq_pkg::OP_LOAD: begin
            cmd_in    = req_data.cmd;
            val_in    = req_data.value;
            idx_in    = AW'(count_ff);
            status_in = spq_pkg::ST_OK;
         end
         spq_pkg::OP_ERR_EMPTY: begin
            status_in = spq_pkg::ST_EMPTY;
         end
         spq_pkg::OP_ERR_FULL: begin
            status_in = spq_pkg::ST_FULL;
         end
         spq_pkg::OP_PUSH_FIRST: begin
            count_in = CW'(1);
            top_in   = val_ff;
         end
         spq_pkg::OP_PUSH_SHIFT: begin
            idx_in = idx_ff - AW'(1);
         end
         spq_pkg::OP_PUSH_PLACE: begin
            count_in = count_ff + CW'(1);
            if (val_ff > top_ff) begin
               top_in = val_ff;
            end
         end
         spq_pkg::OP_POP_LAST: begin
            count_in = '0;
         end
         spq_pkg::OP_POP_TOP: begin
            top_in   = ram_rd_data;
            count_in = count_ff - CW'(1);
         end
         spq_pkg::OP_RESP: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.top_value = (count_ff == '0) ? '0 : top_ff;
            rsp_data_in.is_empty  = (count_ff == '0);
            rsp_data_in.status    = status_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      top_ff      <= top_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      dp_status.is_push  = (cmd_ff == spq_pkg::CMD_PUSH);
      dp_status.is_pop   = (cmd_ff == spq_pkg::CMD_POP);
      dp_status.full     = (count_ff == CW'(DEPTH));
      dp_status.empty    = (count_ff == '0);
      dp_status.one      = (count_ff == CW'(1));
      // equal entries move up so the newest equal value leaves last
      dp_status.shift    = ($signed(ram_rd_data) >= val_ff);
      dp_status.idx_one  = (idx_ff == AW'(1));
      dp_status.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/sorted_priority_queue.sv */
// Bounded max-priority queue of signed 32-bit values. Each transaction is a
// push, a pop of the largest value or a peek, and returns the new top, an
// empty flag and a status; equal values leave in arrival order. Entries sit
// in a one-write, one-read RAM in ascending order, so a pop only reads the
// next top, while a push walks down from the top end moving larger-or-equal
// entries up one slot. For each entry it compares, a push passes through a
// read state for the registered RAM read and a compare state, and it takes
// one more place state when the value lands at the bottom. One transaction
// is worked at a time; the next is accepted while a finished result waits
// to be taken.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Top level: controller and datapath of the sorted priority queue.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);

   spq_pkg::op_type        dp_op;
   spq_pkg::dp_status_type dp_status;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_op     (dp_op)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_op     (dp_op),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input spq_pkg::rsp_type rsp_data
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> rsp_data.top_value == '0)
      else $error("empty queue reports nonzero top");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == spq_pkg::ST_FULL |-> !rsp_data.is_empty)
      else $error("full refusal on an empty queue");

   a_err_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == spq_pkg::ST_EMPTY |-> rsp_data.is_empty)
      else $error("empty error on a nonempty queue");

   // a request accepted never yields a result in the very next cycle
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !(rsp_valid && rsp_stall) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted priority queue. A driver process feeds
// push, pop and peek transactions from a pending queue. A monitor process
// compares every result with a software copy of the queue kept in sorted
// order. Both sides idle at random. The receiver holds off once for a long
// stretch, so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 1700;
   localparam int QUIET_FROM   = 900;
   localparam int QUIET_TO     = 1200;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_LEN     = 300;
   localparam logic [1:0] CMD_SPARE = 2'd3;   // unused code, behaves as a peek

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   spq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   spq_pkg::rsp_type rsp_data;

   sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   spq_pkg::req_type pending_reqs[$];
   spq_pkg::rsp_type expected_tops[$];

   // shadow copy of the queue, largest value at index 0
   logic signed [spq_pkg::DATA_W-1:0] shadow_entries[QUEUE_DEPTH];
   int shadow_fill = 0;

   int errors       = 0;
   int sent_count   = 0;
   int rcvd_count   = 0;
   int push_count   = 0;
   int pop_count    = 0;
   int peek_count   = 0;
   int full_count   = 0;
   int empty_count  = 0;
   int peak_fill    = 0;
   int hold_cycles  = 0;
   bit hold_done    = 1'b0;

   function automatic spq_pkg::rsp_type apply_queue_op(spq_pkg::req_type r);
      spq_pkg::rsp_type                  res;
      logic signed [spq_pkg::DATA_W-1:0] v;
      int                                pos;
      int                                i;
      v = r.value;
      res.status = spq_pkg::ST_OK;
      if (r.cmd == spq_pkg::CMD_PUSH) begin
         push_count++;
         if (shadow_fill >= QUEUE_DEPTH) begin
            res.status = spq_pkg::ST_FULL;
            full_count++;
         end else begin
            pos = 0;
            // equal values stay ahead of the newcomer
            while (pos < shadow_fill && shadow_entries[pos] >= v)
               pos++;
            for (i = shadow_fill; i > pos; i--)
               shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[pos] = v;
            shadow_fill++;
         end
      end else if (r.cmd == spq_pkg::CMD_POP) begin
         pop_count++;
         if (shadow_fill == 0) begin
            res.status = spq_pkg::ST_EMPTY;
            empty_count++;
         end else begin
            for (i = 0; i + 1 < shadow_fill; i++)
               shadow_entries[i] = shadow_entries[i+1];
            shadow_fill--;
         end
      end else begin
         peek_count++;
         if (shadow_fill == 0) begin
            res.status = spq_pkg::ST_EMPTY;
            empty_count++;
         end
      end
      if (shadow_fill > peak_fill)
         peak_fill = shadow_fill;
      res.top_value = (shadow_fill > 0) ? shadow_entries[0] : '0;
      res.is_empty  = (shadow_fill == 0);
      return res;
   endfunction

   function automatic spq_pkg::req_type make_req(logic [1:0] cmd,
                                                 logic [spq_pkg::DATA_W-1:0] value);
      spq_pkg::req_type r;
      r.cmd   = cmd;
      r.value = value;
      return r;
   endfunction

   // values: full range, a narrow band for ties, extremes, small magnitudes
   function automatic logic [spq_pkg::DATA_W-1:0] random_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50)
         return $urandom;
      else if (pick < 80)
         return spq_pkg::DATA_W'($signed($urandom_range(8)) - 4);
      else if (pick < 90)
         return (pick < 85) ? 32'h7fff_ffff : 32'h8000_0000;
      else
         return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
   endfunction

   // driver
   always @(posedge clock) begin : driver
      bit quiet;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_tops.push_back(apply_queue_op(req_data));
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            quiet = (sent_count >= QUIET_FROM && sent_count < QUIET_TO);
            if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 20)) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin : monitor
      spq_pkg::rsp_type exp_rsp;
      bit               quiet;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rcvd_count++;
            if (expected_tops.size() == 0) begin
               $error("unexpected result transaction: top_value %0d", rsp_data.top_value);
               errors++;
            end else begin
               exp_rsp = expected_tops.pop_front();
               if (rsp_data.top_value !== exp_rsp.top_value) begin
                  $error("top_value: expected %0d, actual %0d",
                         exp_rsp.top_value, rsp_data.top_value);
                  errors++;
               end
               if (rsp_data.is_empty !== exp_rsp.is_empty) begin
                  $error("is_empty: expected %0b, actual %0b",
                         exp_rsp.is_empty, rsp_data.is_empty);
                  errors++;
               end
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d",
                         exp_rsp.status, rsp_data.status);
                  errors++;
               end
            end
         end
         if (rcvd_count == HOLD_AT && !hold_done) begin
            hold_cycles = HOLD_LEN;
            hold_done   = 1'b1;
         end
         quiet = (rcvd_count >= QUIET_FROM && rcvd_count < QUIET_TO);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 20);
         end
      end
   end

   initial begin : stimulus
      int         i;
      int         mode;
      int         pick;
      logic [1:0] cmd;

      // directed: empty queue, extremes, ties, drain past empty
      pending_reqs.push_back(make_req(spq_pkg::CMD_PEEK, 32'h1234_5678));
      pending_reqs.push_back(make_req(spq_pkg::CMD_POP, 32'hffff_ffff));
      pending_reqs.push_back(make_req(CMD_SPARE, 32'h0));
      pending_reqs.push_back(make_req(spq_pkg::CMD_PUSH, 32'h8000_0000));
      pending_reqs.push_back(make_req(spq_pkg::CMD_PUSH, 32'h7fff_ffff));
      pending_reqs.push_back(make_req(spq_pkg::CMD_PUSH, 32'h0000_0000));
      pending_reqs.push_back(make_req(spq_pkg::CMD_PUSH, 32'hffff_ffff));
      pending_reqs.push_back(make_req(spq_pkg::CMD_PUSH, 32'h7fff_ffff));
      pending_reqs.push_back(make_req(spq_pkg::CMD_PUSH, 32'h0000_0001));
      pending_reqs.push_back(make_req(spq_pkg::CMD_PEEK, 32'h0));
      pending_reqs.push_back(make_req(CMD_SPARE, 32'hffff_ffff));
      for (i = 0; i < 6; i++)
         pending_reqs.push_back(make_req(spq_pkg::CMD_POP, 32'h0));
      pending_reqs.push_back(make_req(spq_pkg::CMD_POP, 32'h0));
      pending_reqs.push_back(make_req(spq_pkg::CMD_PEEK, 32'h0));

      // random: blocks biased toward filling, draining or mixed traffic
      mode = 0;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 60 == 0)
            mode = $urandom_range(2);
         pick = $urandom_range(99);
         if (pick < 4)
            cmd = CMD_SPARE;
         else if (pick < 12)
            cmd = spq_pkg::CMD_PEEK;
         else if (mode == 0)
            cmd = (pick < 85) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_POP;
         else if (mode == 1)
            cmd = (pick < 35) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_POP;
         else
            cmd = (pick < 56) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_POP;
         pending_reqs.push_back(make_req(cmd, random_value()));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_valid || expected_tops.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Ran %0d transactions: %0d pushes (%0d refused full), %0d pops, %0d peeks",
               sent_count, push_count, full_count, pop_count, peek_count);
      $display("Empty-queue errors seen: %0d, deepest fill: %0d of %0d",
               empty_count, peak_fill, QUEUE_DEPTH);
      if (errors == 0 && expected_tops.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : watchdog
      #4ms;
      $display("Timeout: %0d results still outstanding", expected_tops.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
sv/spq_pkg.sv
sv/spq_ram.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
bench/testbench.sv
